// ===== rtl/mlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared words, codes and constants of the meter line checker with label
// deduplication.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    // input word op codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_NEW_MSG = 1'b1;

    // result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // line format constants
    localparam logic [7:0] SEPARATOR  = 8'h20;
    localparam logic [7:0] SUM_START  = 8'd32;
    localparam logic [6:0] CHECK_BIAS = 7'd32;

    // field positions within a line
    localparam logic [1:0] FLD_LABEL = 2'd0;
    localparam logic [1:0] FLD_VALUE = 2'd1;
    localparam logic [1:0] FLD_CHECK = 2'd2;
    localparam logic [1:0] FLD_REST  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] computed_check;
        logic [7:0] received_check;
        logic [4:0] stored_count;
    } t_out_word;

    // control broadcast to every table cell
    typedef struct packed {
        logic clear;
        logic shift;
        logic cmp;
    } t_cell_ctrl;

endpackage

// ===== rtl/meter_line_checksum_dedup.sv =====
// ----------------------------------------------------------------------------
// meter_line_checksum_dedup
// Meter line checker: splits each line into label, value and check fields,
// verifies the check character and rejects labels already seen in the
// current message.
// ----------------------------------------------------------------------------
// A byte that does not end a line is taken in the idle state. A byte that
// ends a line is followed by a compare state, in which every table cell
// compares its entry with the line label, and then a decide state that
// decides and inserts; the decide state waits while the previous result is
// still held. The label table is a row of MAX_LABELS cells; a stored label
// enters at the first cell and the others move one place down. The table
// needs no clearing pass after reset. A new-message word yields no result
// word.
module meter_line_checksum_dedup #(
    parameter int MAX_LABELS  = 16,
    parameter int LABEL_CHARS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mlcd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mlcd_pkg::t_out_word o_out_word
);

    localparam int LABEL_W = 8 * LABEL_CHARS;
    localparam int LEN_W   = $clog2(LABEL_CHARS + 1);
    localparam int CNT_W   = $clog2(MAX_LABELS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // line state
    logic [LABEL_W-1:0] r_label, n_label;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic [1:0]         r_fld, n_fld;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_chk, n_chk;
    logic               r_seen, n_seen;
    logic [CNT_W-1:0]   r_count, n_count;

    logic                r_out_valid;
    mlcd_pkg::t_out_word r_out_word;

    logic               w_in_fire;
    logic               w_dec_fire;
    logic               w_any_hit;
    logic               w_store;
    logic [2:0]         w_status;
    logic [6:0]         w_computed;
    logic [CNT_W+4:0]   w_cnt_ext;
    mlcd_pkg::t_cell_ctrl w_ctrl;

    logic               w_valid [MAX_LABELS+1];
    logic [LABEL_W-1:0] w_label [MAX_LABELS+1];
    logic [LEN_W-1:0]   w_len   [MAX_LABELS+1];
    logic [MAX_LABELS-1:0] w_hit;
    logic [MAX_LABELS-1:0] w_valid_vec;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_dec_fire = (r_state == S_DEC) && (!r_out_valid || i_out_ready);

    // line decision
    assign w_any_hit  = |w_hit;
    assign w_computed = {1'b0, r_sum[5:0]} + mlcd_pkg::CHECK_BIAS;

    always_comb begin
        w_store = 1'b0;
        if (w_any_hit && !r_ovf) begin
            w_status = mlcd_pkg::ST_DUPLICATE;
        end else if ({1'b0, w_computed} != r_chk) begin
            w_status = mlcd_pkg::ST_MISMATCH;
        end else if (r_ovf) begin
            w_status = mlcd_pkg::ST_TOO_LONG;
        end else if (r_count >= CNT_W'(MAX_LABELS)) begin
            w_status = mlcd_pkg::ST_FULL;
        end else begin
            w_status = mlcd_pkg::ST_STORED;
            w_store  = 1'b1;
        end
    end

    // cell control
    always_comb begin
        w_ctrl.clear = w_in_fire && (i_in_word.op == mlcd_pkg::OP_NEW_MSG);
        w_ctrl.shift = w_dec_fire && w_store;
        w_ctrl.cmp   = (r_state == S_CMP);
    end

    // byte parser, count and sequencing
    always_comb begin
        n_state = r_state;
        n_label = r_label;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_fld   = r_fld;
        n_sum   = r_sum;
        n_chk   = r_chk;
        n_seen  = r_seen;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in_word.op == mlcd_pkg::OP_NEW_MSG) begin
                        n_count = '0;
                        n_label = '0;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                        n_fld   = mlcd_pkg::FLD_LABEL;
                        n_sum   = mlcd_pkg::SUM_START;
                        n_chk   = '0;
                        n_seen  = 1'b0;
                    end else begin
                        if (i_in_word.char_in == mlcd_pkg::SEPARATOR) begin
                            if (r_fld != mlcd_pkg::FLD_REST) begin
                                n_fld = r_fld + 2'd1;
                            end
                        end else begin
                            case (r_fld)
                                mlcd_pkg::FLD_LABEL: begin
                                    n_sum = r_sum + i_in_word.char_in;
                                    if (r_len < LEN_W'(LABEL_CHARS)) begin
                                        for (int j = 0; j < LABEL_CHARS; j++) begin
                                            if (r_len == LEN_W'(j)) begin
                                                n_label[j*8 +: 8] = i_in_word.char_in;
                                            end
                                        end
                                        n_len = r_len + 1'b1;
                                    end else begin
                                        n_ovf = 1'b1;
                                    end
                                end
                                mlcd_pkg::FLD_VALUE: begin
                                    n_sum = r_sum + i_in_word.char_in;
                                end
                                mlcd_pkg::FLD_CHECK: begin
                                    if (!r_seen) begin
                                        n_chk  = i_in_word.char_in;
                                        n_seen = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        if (i_in_word.last_byte) begin
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (w_dec_fire) begin
                    if (w_store) begin
                        n_count = r_count + 1'b1;
                    end
                    n_label = '0;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_fld   = mlcd_pkg::FLD_LABEL;
                    n_sum   = mlcd_pkg::SUM_START;
                    n_chk   = '0;
                    n_seen  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_label <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_fld   <= mlcd_pkg::FLD_LABEL;
            r_sum   <= mlcd_pkg::SUM_START;
            r_chk   <= '0;
            r_seen  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_label <= n_label;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_fld   <= n_fld;
            r_sum   <= n_sum;
            r_chk   <= n_chk;
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

    // result register
    assign w_cnt_ext = (CNT_W + 5)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_dec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dec_fire) begin
            r_out_word.status         <= w_status;
            r_out_word.computed_check <= w_computed;
            r_out_word.received_check <= r_chk;
            r_out_word.stored_count   <= w_cnt_ext[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // label table: row of cells, new entries enter at cell 0
    assign w_valid[0] = 1'b1;
    assign w_label[0] = r_label;
    assign w_len[0]   = r_len;

    for (genvar g = 0; g < MAX_LABELS; g++) begin : g_cell
        mlcd_cell #(
            .LABEL_W (LABEL_W),
            .LEN_W   (LEN_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_valid[g]),
            .i_prev_label (w_label[g]),
            .i_prev_len   (w_len[g]),
            .i_key_label  (r_label),
            .i_key_len    (r_len),
            .o_valid      (w_valid[g+1]),
            .o_label      (w_label[g+1]),
            .o_len        (w_len[g+1]),
            .o_hit        (w_hit[g])
        );
        assign w_valid_vec[g] = w_valid[g+1];
    end

`ifndef ASSERT_OFF
    // occupied cells track the entry count
    a_cells_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("occupied cells differ from entry count");

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_LABELS)
        else $error("entry count beyond table size");

    // compare cycle is always followed by the decide cycle
    a_cmp_then_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_DEC))
        else $error("compare not followed by decide");

    // a stored line adds exactly one entry
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dec_fire && w_store) |=> (r_count == $past(r_count) + 1'b1))
        else $error("store did not advance entry count");

    // a result is only loaded on a line end
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DEC))
        else $error("result word without line end");
`endif

endmodule

// ===== rtl/mlcd_cell.sv =====
// ----------------------------------------------------------------------------
// mlcd_cell
// One entry of the label table: holds a label and its length, takes its
// neighbor's entry on insert and registers its own match against the key.
// ----------------------------------------------------------------------------
module mlcd_cell #(
    parameter int LABEL_W = 64,
    parameter int LEN_W   = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlcd_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_prev_valid,
    input  logic [LABEL_W-1:0]   i_prev_label,
    input  logic [LEN_W-1:0]     i_prev_len,
    input  logic [LABEL_W-1:0]   i_key_label,
    input  logic [LEN_W-1:0]     i_key_len,
    output logic                 o_valid,
    output logic [LABEL_W-1:0]   o_label,
    output logic [LEN_W-1:0]     o_len,
    output logic                 o_hit
);

    logic               r_valid;
    logic [LABEL_W-1:0] r_label;
    logic [LEN_W-1:0]   r_len;
    logic               r_hit;

    // occupancy flag, shifts along with the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev_valid;
        end
    end

    // entry payload from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_label <= i_prev_label;
            r_len   <= i_prev_len;
        end
    end

    // local match against the broadcast key
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_hit <= r_valid && (r_label == i_key_label) && (r_len == i_key_len);
        end
    end

    assign o_valid = r_valid;
    assign o_label = r_label;
    assign o_len   = r_len;
    assign o_hit   = r_hit;

endmodule
